// File: hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the page table walker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  localparam int AddrBits     = 48;
  localparam int PhysAddrBits = 48;
  localparam int DescBits     = 64;
  localparam int FlagBits     = 5;
  localparam int LevelBits    = 2;
  localparam int IdxBits      = 9;
  localparam int ApbAddrBits  = 5;
  localparam int ApbDataBits  = 64;

  // index shifts per level
  localparam int ShiftL0 = 39;
  localparam int ShiftL1 = 30;
  localparam int ShiftL2 = 21;
  localparam int ShiftL3 = 12;

  // opcodes
  localparam logic OpTranslate  = 1'b0;
  localparam logic OpDescriptor = 1'b1;

  // result kinds
  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  // walk levels
  localparam logic [LevelBits-1:0] Level0 = 2'd0;
  localparam logic [LevelBits-1:0] Level1 = 2'd1;
  localparam logic [LevelBits-1:0] Level2 = 2'd2;
  localparam logic [LevelBits-1:0] Level3 = 2'd3;

  // register indexes
  localparam logic [1:0] RegTableRoot = 2'd0;
  localparam logic [1:0] RegMmioBase  = 2'd1;
  localparam logic [1:0] RegMmioLimit = 2'd2;

  // descriptor bits
  localparam int DescValid  = 0;
  localparam int DescTable  = 1;
  localparam int DescAttrLo = 2;
  localparam int DescUser   = 6;
  localparam int DescRdOnly = 7;
  localparam int DescPxn    = 53;
  localparam int DescUxn    = 54;
  localparam logic [2:0] AttrDevice = 3'd1;

  // flag bits
  localparam int FlPresent  = 0;
  localparam int FlWritable = 1;
  localparam int FlExec     = 2;
  localparam int FlUser     = 3;
  localparam int FlDevice   = 4;

  typedef struct packed {
    logic                opcode;
    logic [AddrBits-1:0] virt_addr;
    logic [DescBits-1:0] descriptor;
  } ptw_in_t;

  typedef struct packed {
    logic                result_kind;
    logic [AddrBits-1:0] read_address;
    logic [AddrBits-1:0] phys_addr;
    logic                fault;
    logic [FlagBits-1:0] permission_flags;
  } ptw_out_t;

  typedef struct packed {
    logic                 busy;
    logic [LevelBits-1:0] level;
    logic [AddrBits-1:0]  pending;
  } ptw_state_t;

  typedef struct packed {
    logic [AddrBits-1:0] table_root;
    logic [AddrBits-1:0] mmio_base;
    logic [AddrBits-1:0] mmio_limit;
  } ptw_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/page_table_walker.sv
// ----------------------------------------------------------------------------
// page_table_walker
// Four-level 4 KiB-granule translation table walker with APB configuration.
// ----------------------------------------------------------------------------
// Takes one item per cycle on cmd, stalling while a result waits for res_ready:
// a translate request starts a walk and yields a read request for the level-0
// descriptor; each descriptor item yields the next read request or the finished
// walk (address, fault, flags). An item goes through an input register, one step
// of decode and address add, and a result register, and the sustained rate is
// one item per cycle while results are taken; the limit is the single walk state
// register that each step reads and updates. Requests during a walk and
// descriptors while idle are dropped without a result.
// Registers sit at byte addresses 0, 8 and 16 (table root, device window
// base, device window limit), 48 bits each in a 64-bit data word.
`default_nettype none

module page_table_walker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  var ptw_pkg::ptw_in_t                cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ptw_pkg::ptw_out_t                   res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptw_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [ptw_pkg::ApbDataBits-1:0]     pwdata,
  output logic [ptw_pkg::ApbDataBits-1:0]     prdata,
  output logic                                pready
);

  localparam int AB = ptw_pkg::AddrBits;

  ptw_pkg::ptw_cfg_t   cfg;
  ptw_pkg::ptw_state_t state;
  ptw_pkg::ptw_state_t state_next;
  ptw_pkg::ptw_in_t    a_item;
  ptw_pkg::ptw_out_t   step_res;
  logic                a_valid;
  logic                step_has;
  logic                a_adv;
  logic                o_space;
  logic                cfg_wr;
  logic [1:0]          reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ptw_pkg::ApbAddrBits-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ptw_pkg::RegTableRoot: cfg.table_root <= pwdata[AB-1:0];
        ptw_pkg::RegMmioBase:  cfg.mmio_base  <= pwdata[AB-1:0];
        ptw_pkg::RegMmioLimit: cfg.mmio_limit <= pwdata[AB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ptw_pkg::RegTableRoot: prdata[AB-1:0] = cfg.table_root;
      ptw_pkg::RegMmioBase:  prdata[AB-1:0] = cfg.mmio_base;
      ptw_pkg::RegMmioLimit: prdata[AB-1:0] = cfg.mmio_limit;
      default:               prdata = '0;
    endcase
  end

  // input register
  assign o_space   = !res_valid || res_ready;
  assign a_adv     = a_valid && (!step_has || o_space);
  assign cmd_ready = !a_valid || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd_ready) begin
      a_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      a_item <= cmd;
    end
  end

  ptw_step u_step (
    .item       (a_item),
    .state      (state),
    .cfg        (cfg),
    .has_result (step_has),
    .result     (step_res),
    .state_next (state_next)
  );

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (a_adv) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_adv && step_has) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && step_has) begin
      res <= step_res;
    end
  end

  // checks
  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !state.busy |-> state.level == ptw_pkg::Level0)
    else $error("walk level nonzero while idle");

  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fault |-> res.permission_flags == '0 && res.phys_addr == '0)
    else $error("fault result carries address or flags");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    a_adv && step_has && step_res.result_kind == ptw_pkg::KindRead |=> state.busy)
    else $error("read request issued without an active walk");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    a_adv && step_has && step_res.result_kind == ptw_pkg::KindDone |=> !state.busy)
    else $error("walk still busy after finishing");

endmodule

`default_nettype wire

// File: hw/rtl/ptw_step.sv
// ----------------------------------------------------------------------------
// ptw_step
// One walk step: decodes a request or descriptor against the walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_step (
  input  var ptw_pkg::ptw_in_t    item,
  input  var ptw_pkg::ptw_state_t state,
  input  var ptw_pkg::ptw_cfg_t   cfg,
  output logic                    has_result,
  output ptw_pkg::ptw_out_t       result,
  output ptw_pkg::ptw_state_t     state_next
);

  localparam logic [63:0] PhysTop = (64'd1 << ptw_pkg::PhysAddrBits) - 64'd1;
  localparam logic [63:0] MaskL3  = PhysTop & ~((64'd1 << ptw_pkg::ShiftL3) - 64'd1);
  localparam logic [63:0] MaskL1  = PhysTop & ~((64'd1 << ptw_pkg::ShiftL1) - 64'd1);
  localparam logic [63:0] MaskL2  = PhysTop & ~((64'd1 << ptw_pkg::ShiftL2) - 64'd1);

  localparam int AB = ptw_pkg::AddrBits;

  logic          d_valid;
  logic          d_table;
  logic [63:0]   d_l3;
  logic [63:0]   d_l1;
  logic [63:0]   d_l2;
  logic [AB-1:0] next_table;
  logic [AB-1:0] pend;
  logic [AB-1:0] idx0_ofs;
  logic [AB-1:0] idx1_ofs;
  logic [AB-1:0] idx2_ofs;
  logic [AB-1:0] idx3_ofs;
  logic [AB-1:0] blk1_pa;
  logic [AB-1:0] blk2_pa;
  logic [AB-1:0] page_pa;
  logic          in_window;
  logic [ptw_pkg::FlagBits-1:0] flags;

  assign d_valid    = item.descriptor[ptw_pkg::DescValid];
  assign d_table    = item.descriptor[ptw_pkg::DescTable];
  assign d_l3       = item.descriptor & MaskL3;
  assign d_l1       = item.descriptor & MaskL1;
  assign d_l2       = item.descriptor & MaskL2;
  assign next_table = d_l3[AB-1:0];
  assign pend       = state.pending;

  // descriptor offsets: index times eight
  assign idx0_ofs = {{(AB-12){1'b0}}, item.virt_addr[ptw_pkg::ShiftL0 +: 9], 3'b000};
  assign idx1_ofs = {{(AB-12){1'b0}}, pend[ptw_pkg::ShiftL1 +: 9], 3'b000};
  assign idx2_ofs = {{(AB-12){1'b0}}, pend[ptw_pkg::ShiftL2 +: 9], 3'b000};
  assign idx3_ofs = {{(AB-12){1'b0}}, pend[ptw_pkg::ShiftL3 +: 9], 3'b000};

  assign blk1_pa = d_l1[AB-1:0] + {{(AB-ptw_pkg::ShiftL1){1'b0}}, pend[ptw_pkg::ShiftL1-1:0]};
  assign blk2_pa = d_l2[AB-1:0] + {{(AB-ptw_pkg::ShiftL2){1'b0}}, pend[ptw_pkg::ShiftL2-1:0]};
  assign page_pa = next_table + {{(AB-ptw_pkg::ShiftL3){1'b0}}, pend[ptw_pkg::ShiftL3-1:0]};

  // empty or inverted window never matches
  assign in_window = (pend >= cfg.mmio_base) && (pend < cfg.mmio_limit);

  always_comb begin
    flags = '0;
    flags[ptw_pkg::FlPresent]  = 1'b1;
    flags[ptw_pkg::FlDevice]   = in_window ||
                                 (item.descriptor[ptw_pkg::DescAttrLo +: 3] == ptw_pkg::AttrDevice);
    flags[ptw_pkg::FlWritable] = !item.descriptor[ptw_pkg::DescRdOnly];
    flags[ptw_pkg::FlExec]     = !item.descriptor[ptw_pkg::DescUxn] ||
                                 !item.descriptor[ptw_pkg::DescPxn];
    flags[ptw_pkg::FlUser]     = item.descriptor[ptw_pkg::DescUser];
  end

  always_comb begin
    has_result = 1'b0;
    result     = '0;
    state_next = state;
    if (item.opcode == ptw_pkg::OpTranslate) begin
      if (!state.busy) begin
        has_result          = 1'b1;
        result.result_kind  = ptw_pkg::KindRead;
        result.read_address = cfg.table_root + idx0_ofs;
        state_next.busy     = 1'b1;
        state_next.level    = ptw_pkg::Level0;
        state_next.pending  = item.virt_addr;
      end
    end else if (state.busy) begin
      has_result         = 1'b1;
      result.result_kind = ptw_pkg::KindDone;
      state_next.busy    = 1'b0;
      state_next.level   = ptw_pkg::Level0;
      if (!d_valid) begin
        result.fault = 1'b1;
      end else begin
        unique case (state.level)
          ptw_pkg::Level0: begin
            if (!d_table) begin
              result.fault = 1'b1;
            end else begin
              result.result_kind  = ptw_pkg::KindRead;
              result.read_address = next_table + idx1_ofs;
              state_next.busy     = 1'b1;
              state_next.level    = ptw_pkg::Level1;
            end
          end
          ptw_pkg::Level1: begin
            if (!d_table) begin
              result.phys_addr        = blk1_pa;
              result.permission_flags = flags;
            end else begin
              result.result_kind  = ptw_pkg::KindRead;
              result.read_address = next_table + idx2_ofs;
              state_next.busy     = 1'b1;
              state_next.level    = ptw_pkg::Level2;
            end
          end
          ptw_pkg::Level2: begin
            if (!d_table) begin
              result.phys_addr        = blk2_pa;
              result.permission_flags = flags;
            end else begin
              result.result_kind  = ptw_pkg::KindRead;
              result.read_address = next_table + idx3_ofs;
              state_next.busy     = 1'b1;
              state_next.level    = ptw_pkg::Level3;
            end
          end
          ptw_pkg::Level3: begin
            result.phys_addr        = page_pa;
            result.permission_flags = flags;
          end
          default: begin
            result.fault = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page table walker: walk sequences with random
// descriptors and stray items, predicted per accepted item and checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  ptw_pkg::ptw_in_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  ptw_pkg::ptw_out_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ptw_pkg::ApbAddrBits-1:0] paddr = '0;
  logic [ptw_pkg::ApbDataBits-1:0] pwdata = '0;
  logic [ptw_pkg::ApbDataBits-1:0] prdata;
  logic pready;

  // predicted walker state and register copies
  logic walk_active = 1'b0;
  logic [ptw_pkg::LevelBits-1:0] walk_lvl = ptw_pkg::Level0;
  logic [ptw_pkg::AddrBits-1:0] walk_va = '0;
  logic [ptw_pkg::AddrBits-1:0] cfg_root = '0;
  logic [ptw_pkg::AddrBits-1:0] cfg_base = '0;
  logic [ptw_pkg::AddrBits-1:0] cfg_limit = '0;

  ptw_pkg::ptw_in_t cmd_items[$];
  ptw_pkg::ptw_out_t walk_results_due[$];
  int send_idle_pct = 10;
  int recv_idle_pct = 72;
  int errors_seen = 0;
  int items_made = 0;
  int cycle_count = 0;

  page_table_walker uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ptw_pkg::DescBits-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ptw_pkg::AddrBits-1:0] rand48();
    logic [ptw_pkg::DescBits-1:0] v;
    v = rand64();
    return v[ptw_pkg::AddrBits-1:0];
  endfunction

  function automatic logic [ptw_pkg::FlagBits-1:0] decode_perms(
      input logic [ptw_pkg::DescBits-1:0] d);
    logic [ptw_pkg::FlagBits-1:0] f;
    f = '0;
    f[ptw_pkg::FlPresent] = 1'b1;
    f[ptw_pkg::FlDevice] = (d[ptw_pkg::DescAttrLo +: 3] == ptw_pkg::AttrDevice) ||
                           (walk_va >= cfg_base && walk_va < cfg_limit);
    f[ptw_pkg::FlWritable] = !d[ptw_pkg::DescRdOnly];
    f[ptw_pkg::FlExec] = !d[ptw_pkg::DescUxn] || !d[ptw_pkg::DescPxn];
    f[ptw_pkg::FlUser] = d[ptw_pkg::DescUser];
    return f;
  endfunction

  // advances the predicted walk by one item; returns 1 when a result is due
  function automatic bit walk_step(input ptw_pkg::ptw_in_t it,
                                   output ptw_pkg::ptw_out_t r);
    logic [ptw_pkg::DescBits-1:0] d;
    logic [ptw_pkg::AddrBits-1:0] next_base;
    int shift;
    d = it.descriptor;
    next_base = {d[ptw_pkg::PhysAddrBits-1:ptw_pkg::ShiftL3], 12'h000};
    r = '0;
    if (it.opcode == ptw_pkg::OpTranslate) begin
      if (walk_active) return 1'b0;
      walk_active = 1'b1;
      walk_lvl = ptw_pkg::Level0;
      walk_va = it.virt_addr;
      r.result_kind = ptw_pkg::KindRead;
      r.read_address = cfg_root +
                       {36'd0, walk_va[ptw_pkg::ShiftL0 +: ptw_pkg::IdxBits], 3'b000};
      return 1'b1;
    end
    if (!walk_active) return 1'b0;
    if (!d[ptw_pkg::DescValid] ||
        (walk_lvl == ptw_pkg::Level0 && !d[ptw_pkg::DescTable])) begin
      r.result_kind = ptw_pkg::KindDone;
      r.fault = 1'b1;
      walk_active = 1'b0;
      walk_lvl = ptw_pkg::Level0;
    end else if (walk_lvl == ptw_pkg::Level3 || !d[ptw_pkg::DescTable]) begin
      r.result_kind = ptw_pkg::KindDone;
      case (walk_lvl)
        ptw_pkg::Level1: r.phys_addr = {d[ptw_pkg::PhysAddrBits-1:ptw_pkg::ShiftL1],
                                        walk_va[ptw_pkg::ShiftL1-1:0]};
        ptw_pkg::Level2: r.phys_addr = {d[ptw_pkg::PhysAddrBits-1:ptw_pkg::ShiftL2],
                                        walk_va[ptw_pkg::ShiftL2-1:0]};
        default: r.phys_addr = {next_base[ptw_pkg::AddrBits-1:ptw_pkg::ShiftL3],
                                walk_va[ptw_pkg::ShiftL3-1:0]};
      endcase
      r.permission_flags = decode_perms(d);
      walk_active = 1'b0;
      walk_lvl = ptw_pkg::Level0;
    end else begin
      walk_lvl = walk_lvl + 1'b1;
      case (walk_lvl)
        ptw_pkg::Level1: shift = ptw_pkg::ShiftL1;
        ptw_pkg::Level2: shift = ptw_pkg::ShiftL2;
        default: shift = ptw_pkg::ShiftL3;
      endcase
      r.result_kind = ptw_pkg::KindRead;
      r.read_address = next_base + {36'd0, walk_va[shift +: ptw_pkg::IdxBits], 3'b000};
    end
    return 1'b1;
  endfunction

  // driver: presents queued items, predicts each one at acceptance
  always @(posedge clk) begin : driver
    ptw_pkg::ptw_out_t due;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        if (walk_step(cmd, due)) walk_results_due.push_back(due);
      end
      if (!cmd_valid || cmd_ready) begin
        if (cmd_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd <= cmd_items.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors_seen++;
    end
  endtask

  always @(posedge clk) begin : monitor
    ptw_pkg::ptw_out_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (walk_results_due.size() == 0) begin
          $error("result with nothing expected: %h", res);
          errors_seen++;
        end else begin
          want = walk_results_due.pop_front();
          check_field("result_kind", 64'(want.result_kind), 64'(res.result_kind));
          check_field("read_address", 64'(want.read_address), 64'(res.read_address));
          check_field("phys_addr", 64'(want.phys_addr), 64'(res.phys_addr));
          check_field("fault", 64'(want.fault), 64'(res.fault));
          check_field("permission_flags", 64'(want.permission_flags),
                      64'(res.permission_flags));
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 300000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx,
                           input logic [ptw_pkg::AddrBits-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= 64'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ptw_pkg::RegTableRoot: cfg_root = value;
      ptw_pkg::RegMmioBase: cfg_base = value;
      default: cfg_limit = value;
    endcase
  endtask

  task automatic set_config(input logic [ptw_pkg::AddrBits-1:0] root,
                            input logic [ptw_pkg::AddrBits-1:0] base,
                            input logic [ptw_pkg::AddrBits-1:0] limit);
    write_reg(ptw_pkg::RegTableRoot, root);
    write_reg(ptw_pkg::RegMmioBase, base);
    write_reg(ptw_pkg::RegMmioLimit, limit);
  endtask

  // all items accepted, all results in, then a pause for dropped items to pass
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_items.size() != 0 || cmd_valid || walk_results_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [ptw_pkg::AddrBits-1:0] va,
                           input logic [ptw_pkg::DescBits-1:0] d);
    ptw_pkg::ptw_in_t it;
    it.opcode = op;
    it.virt_addr = va;
    it.descriptor = d;
    cmd_items.push_back(it);
  endtask

  function automatic logic [ptw_pkg::AddrBits-1:0] pick_va();
    logic [ptw_pkg::AddrBits-1:0] span;
    span = cfg_limit - cfg_base;
    case ($urandom_range(9))
      0: return cfg_base;
      1: return cfg_base - 1'b1;
      2: return cfg_limit;
      3: return cfg_limit - 1'b1;
      4: if (cfg_limit > cfg_base) return cfg_base + 48'(rand64() % 64'(span));
      default: return rand48();
    endcase
    return rand48();
  endfunction

  // one well-formed walk with random content, plus occasional stray items
  task automatic gen_walk();
    logic [ptw_pkg::DescBits-1:0] d;
    int lvl;
    int pick;
    bit done;
    if ($urandom_range(99) < 4) push_item(ptw_pkg::OpDescriptor, rand48(), rand64());
    push_item(ptw_pkg::OpTranslate, pick_va(), rand64());
    items_made++;
    lvl = 0;
    done = 1'b0;
    while (!done) begin
      if ($urandom_range(99) < 4) push_item(ptw_pkg::OpTranslate, rand48(), rand64());
      d = rand64();
      pick = $urandom_range(99);
      if (pick < 8) begin
        d[ptw_pkg::DescValid] = 1'b0;
      end else if (pick < 78) begin
        d[ptw_pkg::DescValid] = 1'b1;
        d[ptw_pkg::DescTable] = 1'b1;
      end else begin
        d[ptw_pkg::DescValid] = 1'b1;
        if (lvl < 3) d[ptw_pkg::DescTable] = 1'b0;
      end
      push_item(ptw_pkg::OpDescriptor, rand48(), d);
      items_made++;
      done = !d[ptw_pkg::DescValid] || !d[ptw_pkg::DescTable] || lvl == 3;
      lvl++;
    end
  endtask

  initial begin : stimulus
    logic [ptw_pkg::DescBits-1:0] tbl;
    logic [ptw_pkg::AddrBits-1:0] root_pick;
    logic [ptw_pkg::AddrBits-1:0] base_pick;
    int batch;
    tbl = 64'h0000_0000_0012_3003;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 72;

    // unaligned root near the top so the level-0 address wraps
    set_config(48'hFFFF_FFFF_FF00, 48'h0000_4000_0000, 48'h0000_8000_0000);
    push_item(ptw_pkg::OpDescriptor, '1, '1);
    push_item(ptw_pkg::OpTranslate, '1, '0);
    push_item(ptw_pkg::OpTranslate, '0, '1);
    push_item(ptw_pkg::OpDescriptor, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    // 1 GiB block: device attribute, read-only, never executable, user
    push_item(ptw_pkg::OpTranslate, '0, '0);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, 64'h0060_0000_8000_00C5);
    // 2 MiB block inside the device window, tables at the top address
    push_item(ptw_pkg::OpTranslate, 48'h0000_5555_5555, '0);
    push_item(ptw_pkg::OpDescriptor, '0, '1);
    push_item(ptw_pkg::OpDescriptor, '0, '1);
    push_item(ptw_pkg::OpDescriptor, '0, 64'h0000_FFFF_FFE0_0001);
    // 4 KiB page with the table bit clear
    push_item(ptw_pkg::OpTranslate, 48'h7FFF_FFFF_FFFF, '0);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, 64'h0040_0000_0000_0001);
    // faults at level 1, level 3, and a block at level 0
    push_item(ptw_pkg::OpTranslate, rand48(), '0);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, '0);
    push_item(ptw_pkg::OpTranslate, rand48(), '0);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, tbl);
    push_item(ptw_pkg::OpDescriptor, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    push_item(ptw_pkg::OpTranslate, rand48(), '0);
    push_item(ptw_pkg::OpDescriptor, '0, 64'h0000_0000_4000_0001);

    for (batch = 0; batch < 9; batch++) begin
      wait_idle();
      case (batch / 3)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (batch)
        0: set_config('0, '0, '0);
        1: set_config('1, '1, '1);
        2: set_config(48'hFFFF_FFFF_F000, '0, '1);
        3: set_config(48'h0000_0000_1000, 48'h8000_0000_0000, 48'h1000_0000_0000);
        default: begin
          root_pick = rand48();
          base_pick = rand48();
          set_config({root_pick[ptw_pkg::AddrBits-1:12], 12'h000}, base_pick,
                     base_pick + (rand48() >> 8));
        end
      endcase
      items_made = 0;
      while (items_made < 200) gen_walk();
    end

    wait_idle();
    if (errors_seen == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: page_table_walker.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_step.sv
hw/rtl/page_table_walker.sv
dv/tb_top.sv
